// ===== rtl/hclp_pkg.sv =====
// Package for the hex color line parser.
// Holds the character codes, line geometry and the result struct shared by the line check and the top level.
// No dependencies.
`default_nettype none

package hclp_pkg;

    localparam int unsigned LINE_MAX  = 7;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned DIGITS    = 6;

    localparam logic [7:0] CHAR_BS      = 8'd8;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_DEL     = 8'd127;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [3:0] HEX_TEN      = 4'd10;

    localparam logic STATUS_INVALID = 1'b0;
    localparam logic STATUS_VALID   = 1'b1;

    typedef logic [7:0] t_char;
    typedef t_char t_line [LINE_MAX];

    typedef struct packed {
        logic       status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/hclp_stream_if.sv =====
// Valid/ready channel interfaces for the hex color line parser.
// Depends on nothing; one interface for received bytes, one for color results.
`default_nettype none

interface hclp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hclp_color_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output status, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input status, input red, input green, input blue,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/hclp_line_check.sv =====
// Format check and hex decode of a stored line.
// Depends on hclp_pkg; purely combinational.
`default_nettype none

module hclp_line_check (
    input  hclp_pkg::t_line              i_line,
    input  logic [hclp_pkg::CNT_W-1:0]   i_count,
    output hclp_pkg::t_result            o_result
);

    logic [3:0] dig_val [hclp_pkg::DIGITS];
    logic [hclp_pkg::DIGITS-1:0] dig_ok;
    logic line_ok;

    always_comb begin
        for (int i = 0; i < hclp_pkg::DIGITS; i++) begin
            dig_val[i] = 4'd0;
            dig_ok[i]  = 1'b0;
            if (i_line[i+1] >= hclp_pkg::CHAR_ZERO && i_line[i+1] <= hclp_pkg::CHAR_NINE) begin
                dig_val[i] = 4'(i_line[i+1] - hclp_pkg::CHAR_ZERO);
                dig_ok[i]  = 1'b1;
            end else if (i_line[i+1] >= hclp_pkg::CHAR_UPPER_A &&
                         i_line[i+1] <= hclp_pkg::CHAR_UPPER_F) begin
                dig_val[i] = 4'(i_line[i+1] - hclp_pkg::CHAR_UPPER_A) + hclp_pkg::HEX_TEN;
                dig_ok[i]  = 1'b1;
            end
        end
    end

    assign line_ok = (i_count == hclp_pkg::CNT_W'(hclp_pkg::LINE_MAX)) &&
                     (i_line[0] == hclp_pkg::CHAR_HASH) && (&dig_ok);

    always_comb begin
        o_result.status = hclp_pkg::STATUS_INVALID;
        o_result.red    = 8'd0;
        o_result.green  = 8'd0;
        o_result.blue   = 8'd0;
        if (line_ok) begin
            o_result.status = hclp_pkg::STATUS_VALID;
            o_result.red    = {dig_val[0], dig_val[1]};
            o_result.green  = {dig_val[2], dig_val[3]};
            o_result.blue   = {dig_val[4], dig_val[5]};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hex_color_line_parser.sv =====
// Hex color line parser, top level.
// Depends on hclp_pkg, hclp_stream_if and hclp_line_check.
//
// Usage:
//   i_rx carries received bytes, one item per byte. Letters a..z are folded
//   to uppercase and appended to a line of up to seven characters; BS or DEL
//   drops the last character, characters beyond seven are dropped, and CR
//   ends the line. Every CR gives one item on o_color: status 1 with red,
//   green and blue when the line reads '#' plus six hex digits, otherwise
//   status 0 with zero colors. The line is then empty again.
//   Throughput: one byte per cycle, sustained, also while results flow out,
//   as long as no CR is held in the input register (see below). A CR goes
//   through the input register and then into the result register, which
//   drives o_color.valid and holds the item until it is taken.
//   A result waits in the result register while o_color.ready is low.
//   Ordinary bytes keep flowing into the line during the stall until a
//   further CR reaches the input register; that CR is held there and i_rx
//   stalls until the result register frees up.
//   Reset (synchronous, active low) empties both registers and the line.
`default_nettype none

module hex_color_line_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hclp_rx_if.sink             i_rx,
    hclp_color_if.source        o_color
);

    logic                        r_in_vld;
    logic [7:0]                  r_in_byte;
    logic [hclp_pkg::CNT_W-1:0]  r_count;
    logic [hclp_pkg::CNT_W-1:0]  n_count;
    hclp_pkg::t_line             r_store;
    hclp_pkg::t_char             n_char;
    logic                        r_out_vld;
    hclp_pkg::t_result           r_out;
    hclp_pkg::t_result           chk_result;

    logic is_cr;
    logic is_erase;
    logic out_free;
    logic stage_adv;
    logic store_wr;

    assign is_cr     = (r_in_byte == hclp_pkg::CHAR_CR);
    assign is_erase  = (r_in_byte == hclp_pkg::CHAR_BS) || (r_in_byte == hclp_pkg::CHAR_DEL);
    assign out_free  = !r_out_vld || o_color.ready;
    // only a line end needs room in the result register
    assign stage_adv = r_in_vld && (!is_cr || out_free);
    assign i_rx.ready = !r_in_vld || stage_adv;

    assign store_wr = stage_adv && !is_cr && !is_erase &&
                      (r_count != hclp_pkg::CNT_W'(hclp_pkg::LINE_MAX));

    always_comb begin
        n_char = r_in_byte;
        if (r_in_byte >= hclp_pkg::CHAR_LOWER_A && r_in_byte <= hclp_pkg::CHAR_LOWER_Z) begin
            n_char = r_in_byte - hclp_pkg::CASE_OFFSET;
        end
    end

    always_comb begin
        n_count = r_count;
        if (stage_adv) begin
            if (is_cr) begin
                n_count = '0;
            end else if (is_erase) begin
                if (r_count != '0) begin
                    n_count = r_count - hclp_pkg::CNT_W'(1);
                end
            end else if (store_wr) begin
                n_count = r_count + hclp_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[r_count] <= n_char;
        end
    end

    hclp_line_check u_check (
        .i_line   (r_store),
        .i_count  (r_count),
        .o_result (chk_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (stage_adv && is_cr) begin
            r_out_vld <= 1'b1;
        end else if (o_color.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv && is_cr) begin
            r_out <= chk_result;
        end
    end

    assign o_color.valid  = r_out_vld;
    assign o_color.status = r_out.status;
    assign o_color.red    = r_out.red;
    assign o_color.green  = r_out.green;
    assign o_color.blue   = r_out.blue;

    // hold a line end while the result register is blocked
    a_cr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && is_cr && r_out_vld && !o_color.ready) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("line end left input register while result stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_color.valid && !o_color.status) |->
            (o_color.red == 8'd0 && o_color.green == 8'd0 && o_color.blue == 8'd0))
        else $error("invalid result carries nonzero color");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_adv && is_cr) |=> (r_count == '0))
        else $error("line not cleared after line end");

    a_out_from_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_in_vld && is_cr))
        else $error("result appeared without a line end");

endmodule

`default_nettype wire
